// ===== src/touch_virtual_keypad_tracker_macros.svh =====
// ============================================================================
// Touch virtual keypad tracker assertion macros
// Shared concurrent assertion forms; they compile to nothing when SYNTH is set.
// ============================================================================
`ifndef TOUCH_VIRTUAL_KEYPAD_TRACKER_MACROS_SVH
`define TOUCH_VIRTUAL_KEYPAD_TRACKER_MACROS_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define TVK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tvk: implication check failed");
// Antecedent implies consequent in the next cycle.
`define TVK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tvk: next-cycle check failed");
// Expression must never hold.
`define TVK_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("tvk: forbidden condition seen");
`else
`define TVK_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TVK_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`define TVK_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== src/tvk_pkg.sv =====
// ============================================================================
// Touch virtual keypad tracker package
// Widths, codes and types shared by the keypad tracker files.
// ============================================================================
package tvk_pkg;

  localparam int KeyCount       = 8;
  localparam int SlotW          = 3;
  localparam int PairCount      = 4;
  localparam int CoordW         = 12;
  localparam int TagW           = 16;
  localparam int DistW          = 2 * CoordW + 1;
  localparam int FingerSlotsDef = 10;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 48;
  localparam int ReqTypeW       = 2;

  localparam logic [DistW-1:0] RadiusRst = DistW'(576);

  // Event kinds.
  localparam logic [ReqTypeW-1:0] REQ_DOWN   = 2'd0;
  localparam logic [ReqTypeW-1:0] REQ_UP     = 2'd1;
  localparam logic [ReqTypeW-1:0] REQ_MOTION = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_KEY_PAIR_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_PAIR_1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_PAIR_2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_PAIR_3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS     = 3'd4;

  typedef struct packed {
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } tvk_point_t;

endpackage

// ===== src/tvk_req_if.sv =====
// ============================================================================
// Touch event channel
// Valid/ready channel that carries one touch event item.
// ============================================================================
interface tvk_req_if import tvk_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [TagW-1:0]     finger_tag;
  logic [CoordW-1:0]   pos_x;
  logic [CoordW-1:0]   pos_y;

  modport source (output valid, req_type, finger_tag, pos_x, pos_y, input ready);
  modport sink   (input valid, req_type, finger_tag, pos_x, pos_y, output ready);
endinterface

// ===== src/tvk_res_if.sv =====
// ============================================================================
// Key change channel
// Valid/ready channel that carries one key press, release or error item.
// ============================================================================
interface tvk_res_if import tvk_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SlotW-1:0] key_slot;
  logic             now_pressed;
  logic             table_full;
  logic             last_of_run;

  modport source (output valid, key_slot, now_pressed, table_full, last_of_run,
                  input ready);
  modport sink   (input valid, key_slot, now_pressed, table_full, last_of_run,
                  output ready);
endinterface

// ===== src/tvk_dist.sv =====
// ============================================================================
// Squared distance unit
// Registered squared distance between a touch point and one key center.
// ============================================================================
module tvk_dist import tvk_pkg::*; (
  input  logic             clk_i,
  input  tvk_point_t       pt_i,
  input  tvk_point_t       ctr_i,
  output logic [DistW-1:0] dist_o
);

  logic [CoordW-1:0]   dx, dy;
  logic [2*CoordW-1:0] sq_x, sq_y;
  logic [DistW-1:0]    dist_d, dist_q;

  assign dx = (pt_i.x > ctr_i.x) ? (pt_i.x - ctr_i.x) : (ctr_i.x - pt_i.x);
  assign dy = (pt_i.y > ctr_i.y) ? (pt_i.y - ctr_i.y) : (ctr_i.y - pt_i.y);

  assign sq_x   = {{CoordW{1'b0}}, dx} * {{CoordW{1'b0}}, dx};
  assign sq_y   = {{CoordW{1'b0}}, dy} * {{CoordW{1'b0}}, dy};
  assign dist_d = {1'b0, sq_x} + {1'b0, sq_y};

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;

endmodule

// ===== src/touch_virtual_keypad_tracker.sv =====
// ============================================================================
// Touch virtual keypad tracker
// Maps multi-finger touch events onto presses and releases of eight keys.
// ============================================================================
// An item goes through a finger lookup, up to two passes of the shared distance
// unit over the eight keys, a rebuild of the pressed set and, when keys change,
// a result walk, or else an error item when the table is full. A new item is
// taken only once the sequencer is back in idle. Reset clears the table valid
// bits, the pressed set and the sequencer; key centers reset to 0 and the
// radius to 576.
`include "touch_virtual_keypad_tracker_macros.svh"

module touch_virtual_keypad_tracker import tvk_pkg::*; #(
  parameter int FINGER_SLOTS = FingerSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tvk_req_if.sink             req_i,
  tvk_res_if.source           res_o
);

  // Width of a finger table index; a one-entry table still gets one bit.
  localparam int IdxW = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FINGER_SLOTS - 1);
  // The key counter runs one step past the last key so that the registered
  // distance of the last key can still be compared.
  localparam int KW = $clog2(KeyCount) + 1;
  localparam logic [KW-1:0] KeyEnd = KW'(KeyCount);
  // Width of the scaled compare for the second key threshold.
  localparam int ThrW = DistW + 4;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOOK    = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_PASS1   = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_PASS2   = 4'd5;
  localparam logic [3:0] S_COMMIT  = 4'd6;
  localparam logic [3:0] S_REBUILD = 4'd7;
  localparam logic [3:0] S_DIFF    = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;
  localparam logic [3:0] S_ERR     = 4'd10;

  // Configuration registers.
  logic [CfgDataW-1:0] key_pair_q [PairCount];
  logic [DistW-1:0]    radius_q;

  // Finger table. Valid bits reset; the payload fields only matter while valid.
  logic [FINGER_SLOTS-1:0] prim_ok_q, sec_ok_q;
  logic [TagW-1:0]         tag_tbl_q [FINGER_SLOTS];
  logic [SlotW-1:0]        prim_q    [FINGER_SLOTS];
  logic [SlotW-1:0]        sec_q     [FINGER_SLOTS];

  // Sequencer and working registers.
  logic [3:0]          state_q, state_d;
  logic [IdxW-1:0]     scan_q, scan_d;
  logic [KW-1:0]       k_q, k_d;
  logic [ReqTypeW-1:0] type_q, type_d;
  logic [TagW-1:0]     tag_q, tag_d;
  tvk_point_t          pt_q, pt_d;
  logic                hit_ok_q, hit_ok_d, free_ok_q, free_ok_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, tgt_q, tgt_d;
  logic [DistW-1:0]    best_q, best_d, second_q, second_d;
  logic [SlotW-1:0]    bi_q, bi_d, si_q, si_d;
  logic                have_q, have_d;
  logic [KeyCount-1:0] now_q, now_d, pressed_q, pressed_d, diff_q, diff_d;

  // Output register.
  logic             out_valid_q;
  logic [SlotW-1:0] out_slot_q;
  logic             out_now_q, out_full_q, out_last_q;

  // Table write and output load controls.
  logic             tbl_we, w_prim_ok, w_sec_ok;
  logic [IdxW-1:0]  tbl_idx;
  logic             out_load, out_free;
  logic [SlotW-1:0] ld_slot;
  logic             ld_now, ld_full, ld_last;

  // Distance unit hookup.
  logic [CfgDataW-1:0] sel_pair;
  tvk_point_t          ctr;
  logic [DistW-1:0]    dist_val;
  logic [SlotW-1:0]    kj_prev, kj;
  logic [ThrW-1:0]     sec_lhs, best_x16;
  logic                type_known;

  // --------------------------------------------------------------------------
  // Configuration writes. Indexes beyond the register list are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PairCount; p++) begin
        key_pair_q[p] <= '0;
      end
      radius_q <= RadiusRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_PAIR_0: key_pair_q[0] <= cfg_data_i;
        CFG_KEY_PAIR_1: key_pair_q[1] <= cfg_data_i;
        CFG_KEY_PAIR_2: key_pair_q[2] <= cfg_data_i;
        CFG_KEY_PAIR_3: key_pair_q[3] <= cfg_data_i;
        CFG_RADIUS:     radius_q      <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Distance unit. The key counter presents key k while the unit's register
  // still holds the distance of key k-1, so each pass steps one past the last key.
  // --------------------------------------------------------------------------
  assign kj       = k_q[SlotW-1:0];
  assign kj_prev  = SlotW'(k_q - KW'(1));
  assign sel_pair = key_pair_q[kj[SlotW-1:1]];
  assign ctr.x    = kj[0] ? sel_pair[35:24] : sel_pair[11:0];
  assign ctr.y    = kj[0] ? sel_pair[47:36] : sel_pair[23:12];

  tvk_dist u_dist (
    .clk_i  (clk_i),
    .pt_i   (pt_q),
    .ctr_i  (ctr),
    .dist_o (dist_val)
  );

  // The second key is bound when second < floor(best*16/10). For integers this
  // is the same as 10*second + 10 <= 16*best, which needs no divider.
  assign sec_lhs  = (ThrW'(second_q) << 3) + (ThrW'(second_q) << 1) + ThrW'(10);
  assign best_x16 = ThrW'(best_q) << 4;

  assign type_known = (req_i.req_type == REQ_DOWN) || (req_i.req_type == REQ_UP) ||
                      (req_i.req_type == REQ_MOTION);
  assign out_free   = !out_valid_q || res_o.ready;

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    k_d        = k_q;
    type_d     = type_q;
    tag_d      = tag_q;
    pt_d       = pt_q;
    hit_ok_d   = hit_ok_q;
    free_ok_d  = free_ok_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    tgt_d      = tgt_q;
    best_d     = best_q;
    second_d   = second_q;
    bi_d       = bi_q;
    si_d       = si_q;
    have_d     = have_q;
    now_d      = now_q;
    pressed_d  = pressed_q;
    diff_d     = diff_q;
    tbl_we     = 1'b0;
    tbl_idx    = tgt_q;
    w_prim_ok  = 1'b0;
    w_sec_ok   = 1'b0;
    out_load   = 1'b0;
    ld_slot    = '0;
    ld_now     = 1'b0;
    ld_full    = 1'b0;
    ld_last    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          type_d    = req_i.req_type;
          tag_d     = req_i.finger_tag;
          pt_d.x    = req_i.pos_x;
          pt_d.y    = req_i.pos_y;
          scan_d    = '0;
          hit_ok_d  = 1'b0;
          free_ok_d = 1'b0;
          // The undefined event kind is taken and dropped without results.
          if (type_known) begin
            state_d = S_LOOK;
          end
        end
      end

      // First matching entry in use wins; otherwise remember the first free one.
      S_LOOK: begin
        if (prim_ok_q[scan_q] && (tag_tbl_q[scan_q] == tag_q)) begin
          hit_ok_d  = 1'b1;
          hit_idx_d = scan_q;
          state_d   = S_DECIDE;
        end else begin
          if (!prim_ok_q[scan_q] && !free_ok_q) begin
            free_ok_d  = 1'b1;
            free_idx_d = scan_q;
          end
          if (scan_q == LastIdx) begin
            state_d = S_DECIDE;
          end else begin
            scan_d = scan_q + IdxW'(1);
          end
        end
      end

      S_DECIDE: begin
        if (type_q == REQ_UP) begin
          // Lifting an unknown finger changes nothing; the rebuild then
          // finds no difference and no result goes out.
          if (hit_ok_q) begin
            tbl_we  = 1'b1;
            tbl_idx = hit_idx_q;
          end
          scan_d  = '0;
          now_d   = '0;
          state_d = S_REBUILD;
        end else if (!hit_ok_q && !free_ok_q) begin
          state_d = S_ERR;
        end else begin
          tgt_d   = hit_ok_q ? hit_idx_q : free_idx_q;
          k_d     = '0;
          state_d = S_PASS1;
        end
      end

      // Nearest key; strict compare keeps the lower slot on a tie.
      S_PASS1: begin
        if ((k_q != '0) && ((k_q == KW'(1)) || (dist_val < best_q))) begin
          best_d = dist_val;
          bi_d   = kj_prev;
        end
        if (k_q == KeyEnd) begin
          state_d = S_CHECK;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      S_CHECK: begin
        if (best_q > radius_q) begin
          // Too far from every key: the entry is written back as free.
          tbl_we  = 1'b1;
          scan_d  = '0;
          now_d   = '0;
          state_d = S_REBUILD;
        end else begin
          k_d     = '0;
          have_d  = 1'b0;
          state_d = S_PASS2;
        end
      end

      // Runner-up key over every slot but the nearest one.
      S_PASS2: begin
        if ((k_q != '0) && (kj_prev != bi_q) && (!have_q || (dist_val < second_q))) begin
          second_d = dist_val;
          si_d     = kj_prev;
          have_d   = 1'b1;
        end
        if (k_q == KeyEnd) begin
          state_d = S_COMMIT;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      S_COMMIT: begin
        tbl_we    = 1'b1;
        w_prim_ok = 1'b1;
        w_sec_ok  = (sec_lhs <= best_x16);
        scan_d    = '0;
        now_d     = '0;
        state_d   = S_REBUILD;
      end

      S_REBUILD: begin
        now_d = now_q
              | (prim_ok_q[scan_q] ? (KeyCount'(1) << prim_q[scan_q]) : '0)
              | (sec_ok_q[scan_q]  ? (KeyCount'(1) << sec_q[scan_q])  : '0);
        if (scan_q == LastIdx) begin
          state_d = S_DIFF;
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end

      S_DIFF: begin
        diff_d    = now_q ^ pressed_q;
        pressed_d = now_q;
        k_d       = '0;
        state_d   = (now_q != pressed_q) ? S_EMIT : S_IDLE;
      end

      // One key per cycle in slot order; a changed key waits for a free
      // output register.
      S_EMIT: begin
        if (!diff_q[kj] || out_free) begin
          if (diff_q[kj]) begin
            out_load = 1'b1;
            ld_slot  = kj;
            ld_now   = pressed_q[kj];
            ld_last  = ((diff_q >> kj) == KeyCount'(1));
          end
          if (kj == SlotW'(KeyCount - 1)) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_full  = 1'b1;
          ld_last  = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pressed_q <= '0;
    end else begin
      state_q   <= state_d;
      pressed_q <= pressed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    k_q        <= k_d;
    type_q     <= type_d;
    tag_q      <= tag_d;
    pt_q       <= pt_d;
    hit_ok_q   <= hit_ok_d;
    free_ok_q  <= free_ok_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    tgt_q      <= tgt_d;
    best_q     <= best_d;
    second_q   <= second_d;
    bi_q       <= bi_d;
    si_q       <= si_d;
    have_q     <= have_d;
    now_q      <= now_d;
    diff_q     <= diff_d;
  end

  // --------------------------------------------------------------------------
  // Finger table writes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_ok_q <= '0;
      sec_ok_q  <= '0;
    end else if (tbl_we) begin
      prim_ok_q[tbl_idx] <= w_prim_ok;
      sec_ok_q[tbl_idx]  <= w_sec_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tag_tbl_q[tbl_idx] <= tag_q;
      prim_q[tbl_idx]    <= bi_q;
      sec_q[tbl_idx]     <= si_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and handshakes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slot_q <= ld_slot;
      out_now_q  <= ld_now;
      out_full_q <= ld_full;
      out_last_q <= ld_last;
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.key_slot    = out_slot_q;
  assign res_o.now_pressed = out_now_q;
  assign res_o.table_full  = out_full_q;
  assign res_o.last_of_run = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A second key is never bound to a free entry.
  `TVK_ASSERT_NEVER(a_sec_needs_prim, clk_i, rst_ni, |(sec_ok_q & ~prim_ok_q))
  // An error item stands alone and carries no press.
  `TVK_ASSERT_IMP(a_err_alone, clk_i, rst_ni, res_o.valid && res_o.table_full, res_o.last_of_run && !res_o.now_pressed)
  // A known event starts the finger lookup right after it is taken.
  `TVK_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, req_i.valid && req_i.ready && type_known, state_q == S_LOOK)
  // A result is only loaded when the previous one has gone or is leaving.
  `TVK_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_load, !out_valid_q || res_o.ready)

endmodule
